/* src/sobel_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel edge package
// Shared widths, payload types, kernel tables and the arithmetic helpers used
// by the gradient and square-root stages.
// ----------------------------------------------------------------------------
package sobel_pkg;

    localparam int DEF_MAX_LINE     = 2048;
    localparam int DEF_LINE_WIDTH   = 640;
    localparam int DEF_FRAME_HEIGHT = 480;

    localparam int PIX_W   = 8;
    localparam int COL_W   = 11;
    localparam int ROW_W   = 16;
    localparam int LW_W    = 12;
    localparam int CFG_W   = 16;
    localparam int GRAD_W  = 11;
    localparam int ABS_W   = 10;
    localparam int SQ_W    = 2 * ABS_W;
    localparam int SUM_W   = SQ_W + 1;
    localparam int ROOT_W  = 16;

    localparam int ROOT_STAGES     = 4;
    localparam int STEPS_PER_STAGE = 2;

    typedef logic [PIX_W-1:0]         pix_t;
    typedef logic [COL_W-1:0]         col_t;
    typedef logic [ROW_W-1:0]         row_t;
    typedef logic [LW_W-1:0]          lw_t;
    typedef logic [CFG_W-1:0]         cfg_data_t;
    typedef logic signed [GRAD_W-1:0] grad_t;
    typedef logic [8:0][PIX_W-1:0]    win_t;

    typedef enum logic {
        REG_LINE_WIDTH   = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic emit;
        col_t col;
        row_t row;
        logic last;
    } meta_t;

    typedef struct packed {
        logic [ROOT_W-1:0] rem;
        logic [ROOT_W-1:0] root;
    } root_t;

    localparam int KERN_X [9] = '{-1, 0, 1, -2, 0, 2, -1, 0, 1};
    localparam int KERN_Y [9] = '{-1, -2, -1, 0, 0, 0, 1, 2, 1};

    // Window index is row * 3 + column, row 0 being two lines up.
    function automatic grad_t sobel_grad(win_t win, logic vertical);
        grad_t acc;
        int    coef;
        acc = '0;
        for (int i = 0; i < 9; i++)
        begin
            coef = vertical ? KERN_Y[i] : KERN_X[i];
            acc  = acc + GRAD_W'(coef * int'(win[i]));
        end
        return acc;
    endfunction

    // One digit of the restoring integer square root of a 16-bit value.
    function automatic root_t sqrt_step(root_t st, int step);
        logic [ROOT_W:0] bit_v;
        logic [ROOT_W:0] trial;
        root_t           nx;
        bit_v = (ROOT_W + 1)'(1) << (14 - 2 * step);
        trial = {1'b0, st.root} + bit_v;
        if ({1'b0, st.rem} >= trial)
        begin
            nx.rem  = ROOT_W'({1'b0, st.rem} - trial);
            nx.root = ROOT_W'(({1'b0, st.root} >> 1) + bit_v);
        end
        else
        begin
            nx.rem  = st.rem;
            nx.root = st.root >> 1;
        end
        return nx;
    endfunction

endpackage

/* src/sobel_linebuf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel line buffers
// Two row memories with registered reads. Each beat reads the two older rows
// at its column and writes the shifted column back on the next pipeline advance.
// ----------------------------------------------------------------------------
module sobel_linebuf #(
    parameter int MAX_LINE = sobel_pkg::DEF_MAX_LINE
) (
    input  logic                 clk,
    input  logic                 adv,
    input  logic                 wr_en,
    input  logic [$clog2(MAX_LINE)-1:0] rd_idx,
    input  sobel_pkg::pix_t      pix,
    output sobel_pkg::pix_t      top_px,
    output sobel_pkg::pix_t      mid_px,
    output sobel_pkg::pix_t      cur_px
);

    localparam int CW = $clog2(MAX_LINE);

    sobel_pkg::pix_t mem_a [MAX_LINE];
    sobel_pkg::pix_t mem_b [MAX_LINE];

    sobel_pkg::pix_t a_q_reg;
    sobel_pkg::pix_t b_q_reg;
    sobel_pkg::pix_t fwd_a_reg;
    sobel_pkg::pix_t fwd_b_reg;
    logic            fwd_reg;
    logic [CW-1:0]   idx_reg;
    sobel_pkg::pix_t pix_reg;

    // A beat that reads the column being written this cycle takes the new
    // contents from the write side instead of the memory.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_q_reg   <= mem_a[rd_idx];
            b_q_reg   <= mem_b[rd_idx];
            fwd_reg   <= wr_en && (idx_reg == rd_idx);
            fwd_a_reg <= pix_reg;
            fwd_b_reg <= mid_px;
            idx_reg   <= rd_idx;
            pix_reg   <= pix;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_a[idx_reg] <= pix_reg;
            mem_b[idx_reg] <= mid_px;
        end
    end

    assign mid_px = fwd_reg ? fwd_a_reg : a_q_reg;
    assign top_px = fwd_reg ? fwd_b_reg : b_q_reg;
    assign cur_px = pix_reg;

endmodule

/* src/sobel_window.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel window and gradients
// Shifts the 3x3 neighborhood by one column per beat and registers the
// horizontal and vertical Sobel gradients of interior pixels.
// ----------------------------------------------------------------------------
module sobel_window (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_vld,
    input  sobel_pkg::meta_t    in_meta,
    input  sobel_pkg::pix_t     top_px,
    input  sobel_pkg::pix_t     mid_px,
    input  sobel_pkg::pix_t     cur_px,
    output logic                out_vld,
    output sobel_pkg::meta_t    out_meta,
    output sobel_pkg::grad_t    gx,
    output sobel_pkg::grad_t    gy
);

    sobel_pkg::win_t  window_reg;
    logic             win_vld_reg;
    sobel_pkg::meta_t win_meta_reg;
    logic             grad_vld_reg;
    sobel_pkg::meta_t grad_meta_reg;
    sobel_pkg::grad_t gx_reg;
    sobel_pkg::grad_t gy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg   <= '0;
            win_vld_reg  <= 1'b0;
            grad_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            if (in_vld)
            begin
                window_reg[0] <= window_reg[1];
                window_reg[1] <= window_reg[2];
                window_reg[2] <= top_px;
                window_reg[3] <= window_reg[4];
                window_reg[4] <= window_reg[5];
                window_reg[5] <= mid_px;
                window_reg[6] <= window_reg[7];
                window_reg[7] <= window_reg[8];
                window_reg[8] <= cur_px;
            end
            win_vld_reg  <= in_vld && in_meta.emit;
            grad_vld_reg <= win_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            win_meta_reg  <= in_meta;
            grad_meta_reg <= win_meta_reg;
            gx_reg        <= sobel_pkg::sobel_grad(window_reg, 1'b0);
            gy_reg        <= sobel_pkg::sobel_grad(window_reg, 1'b1);
        end
    end

    assign out_vld  = grad_vld_reg;
    assign out_meta = grad_meta_reg;
    assign gx       = gx_reg;
    assign gy       = gy_reg;

endmodule

/* src/sobel_mag.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel magnitude
// Squares and sums the gradients, then takes the integer square root two
// digits per stage. The last stage is the output register.
// ----------------------------------------------------------------------------
module sobel_mag (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_vld,
    input  sobel_pkg::meta_t    in_meta,
    input  sobel_pkg::grad_t    gx,
    input  sobel_pkg::grad_t    gy,
    output logic                out_vld,
    output sobel_pkg::pix_t     edge_value,
    output sobel_pkg::col_t     pixel_col,
    output sobel_pkg::row_t     pixel_row,
    output logic                frame_end
);

    localparam int NS = sobel_pkg::ROOT_STAGES;

    logic [sobel_pkg::ABS_W-1:0]  ax;
    logic [sobel_pkg::ABS_W-1:0]  ay;
    logic [sobel_pkg::SQ_W-1:0]   sqx;
    logic [sobel_pkg::SQ_W-1:0]   sqy;
    logic [sobel_pkg::SUM_W-1:0]  sum;

    logic                         sq_vld_reg;
    logic [sobel_pkg::ROOT_W-1:0] sq_lo_reg;
    logic                         sq_sat_reg;
    sobel_pkg::meta_t             sq_meta_reg;

    logic                         rt_vld_reg  [NS];
    sobel_pkg::root_t             rt_reg      [NS];
    logic                         rt_sat_reg  [NS];
    sobel_pkg::meta_t             rt_meta_reg [NS];
    sobel_pkg::root_t             rt_src      [NS];
    sobel_pkg::root_t             rt_next     [NS];

    always_comb
    begin
        ax  = sobel_pkg::ABS_W'(gx[sobel_pkg::GRAD_W-1] ? -gx : gx);
        ay  = sobel_pkg::ABS_W'(gy[sobel_pkg::GRAD_W-1] ? -gy : gy);
        sqx = {{(sobel_pkg::SQ_W - sobel_pkg::ABS_W){1'b0}}, ax}
            * {{(sobel_pkg::SQ_W - sobel_pkg::ABS_W){1'b0}}, ax};
        sqy = {{(sobel_pkg::SQ_W - sobel_pkg::ABS_W){1'b0}}, ay}
            * {{(sobel_pkg::SQ_W - sobel_pkg::ABS_W){1'b0}}, ay};
        sum = {1'b0, sqx} + {1'b0, sqy};
    end

    always_comb
    begin
        rt_src[0].rem  = sq_lo_reg;
        rt_src[0].root = '0;
        for (int j = 1; j < NS; j++)
        begin
            rt_src[j] = rt_reg[j-1];
        end
        for (int j = 0; j < NS; j++)
        begin
            rt_next[j] = rt_src[j];
            for (int s = 0; s < sobel_pkg::STEPS_PER_STAGE; s++)
            begin
                rt_next[j] = sobel_pkg::sqrt_step(rt_next[j],
                                                  j * sobel_pkg::STEPS_PER_STAGE + s);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_vld_reg <= 1'b0;
            for (int j = 0; j < NS; j++)
            begin
                rt_vld_reg[j] <= 1'b0;
            end
        end
        else if (adv)
        begin
            sq_vld_reg    <= in_vld;
            rt_vld_reg[0] <= sq_vld_reg;
            for (int j = 1; j < NS; j++)
            begin
                rt_vld_reg[j] <= rt_vld_reg[j-1];
            end
        end
    end

    // A sum of squares of 65536 or more has a root above 255 and saturates.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_lo_reg      <= sum[sobel_pkg::ROOT_W-1:0];
            sq_sat_reg     <= |sum[sobel_pkg::SUM_W-1:sobel_pkg::ROOT_W];
            sq_meta_reg    <= in_meta;
            rt_sat_reg[0]  <= sq_sat_reg;
            rt_meta_reg[0] <= sq_meta_reg;
            for (int j = 0; j < NS; j++)
            begin
                rt_reg[j] <= rt_next[j];
            end
            for (int j = 1; j < NS; j++)
            begin
                rt_sat_reg[j]  <= rt_sat_reg[j-1];
                rt_meta_reg[j] <= rt_meta_reg[j-1];
            end
        end
    end

    assign out_vld    = rt_vld_reg[NS-1];
    assign edge_value = rt_sat_reg[NS-1] ? '1
                                         : rt_reg[NS-1].root[sobel_pkg::PIX_W-1:0];
    assign pixel_col  = rt_meta_reg[NS-1].col;
    assign pixel_row  = rt_meta_reg[NS-1].row;
    assign frame_end  = rt_meta_reg[NS-1].last;

endmodule

/* src/sobel_edge_magnitude.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel edge magnitude
// Streams a gray image in raster order and emits the saturated Sobel
// gradient magnitude of every interior pixel with its coordinates.
//
//   Channel  Handshake             Payload
//   input    in_valid / in_stall   gray_pixel, frame_start
//   output   out_valid / out_stall edge_value, pixel_col, pixel_row, frame_end
//   config   cfg_wr_en             cfg_index, cfg_data
//
// One pixel beat is taken every cycle while in_stall is low; a result passes
// through the eight pipeline stages after the beat that completes its window
// (line memory read, window, gradients, squares, four square-root stages).
// A stall on the output freezes every stage; in_stall rises only while a
// result waits in the output register.
// Reset clears the position counters and valid bits and sets the size to
// 640 x 480; the line memories are not cleared.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude #(
    parameter int MAX_LINE = sobel_pkg::DEF_MAX_LINE
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  sobel_pkg::pix_t       gray_pixel,
    input  logic                  frame_start,
    output logic                  out_valid,
    input  logic                  out_stall,
    output sobel_pkg::pix_t       edge_value,
    output sobel_pkg::col_t       pixel_col,
    output sobel_pkg::row_t       pixel_row,
    output logic                  frame_end,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_index,
    input  sobel_pkg::cfg_data_t  cfg_data
);

    localparam int CW = $clog2(MAX_LINE);
    localparam int WW = $clog2(MAX_LINE + 1);

    sobel_pkg::lw_t      line_width_reg;
    sobel_pkg::row_t     frame_height_reg;
    logic [CW-1:0]       col_reg;
    logic [CW-1:0]       col_next;
    sobel_pkg::row_t     row_reg;
    sobel_pkg::row_t     row_next;

    logic                adv;
    logic                take;
    logic [WW-1:0]       eff_w;
    sobel_pkg::row_t     eff_h;
    logic [CW-1:0]       cur_col;
    logic [CW-1:0]       col_m1;
    sobel_pkg::row_t     cur_row;
    logic [WW-1:0]       col_inc;
    logic [sobel_pkg::ROW_W:0] row_inc;
    sobel_pkg::meta_t    cur_meta;

    logic                s1_vld_reg;
    sobel_pkg::meta_t    s1_meta_reg;

    sobel_pkg::pix_t     top_px;
    sobel_pkg::pix_t     mid_px;
    sobel_pkg::pix_t     cur_px;
    logic                grad_vld;
    sobel_pkg::meta_t    grad_meta;
    sobel_pkg::grad_t    gx;
    sobel_pkg::grad_t    gy;

    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv;
    assign take     = in_valid && adv;

    always_comb
    begin
        if (32'(line_width_reg) < 32'd3)
        begin
            eff_w = WW'(3);
        end
        else if (32'(line_width_reg) > 32'(MAX_LINE))
        begin
            eff_w = WW'(MAX_LINE);
        end
        else
        begin
            eff_w = WW'(line_width_reg);
        end
        eff_h = (frame_height_reg < 16'd3) ? 16'd3 : frame_height_reg;
    end

    always_comb
    begin
        cur_col = frame_start ? '0 : col_reg;
        cur_row = frame_start ? '0 : row_reg;
        col_inc = WW'(cur_col) + WW'(1);
        row_inc = {1'b0, cur_row} + 17'd1;
        col_m1  = cur_col - CW'(1);

        cur_meta.emit = (cur_col >= CW'(2)) && (cur_row >= 16'd2);
        cur_meta.col  = sobel_pkg::col_t'(col_m1);
        cur_meta.row  = cur_row - 16'd1;
        cur_meta.last = (col_inc == eff_w) && (row_inc == {1'b0, eff_h});

        if (col_inc >= eff_w)
        begin
            col_next = '0;
            row_next = (row_inc >= {1'b0, eff_h}) ? '0 : row_inc[sobel_pkg::ROW_W-1:0];
        end
        else
        begin
            col_next = col_inc[CW-1:0];
            row_next = cur_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg   <= sobel_pkg::LW_W'(sobel_pkg::DEF_LINE_WIDTH);
            frame_height_reg <= sobel_pkg::ROW_W'(sobel_pkg::DEF_FRAME_HEIGHT);
        end
        else if (cfg_wr_en)
        begin
            case (sobel_pkg::cfg_reg_t'(cfg_index))
                sobel_pkg::REG_LINE_WIDTH:
                    line_width_reg <= cfg_data[sobel_pkg::LW_W-1:0];
                sobel_pkg::REG_FRAME_HEIGHT:
                    frame_height_reg <= cfg_data;
                default:
                    line_width_reg <= line_width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (adv)
            begin
                s1_vld_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_meta_reg <= cur_meta;
        end
    end

    sobel_linebuf #(
        .MAX_LINE (MAX_LINE)
    ) u_linebuf (
        .clk    (clk),
        .adv    (adv),
        .wr_en  (adv && s1_vld_reg),
        .rd_idx (cur_col),
        .pix    (gray_pixel),
        .top_px (top_px),
        .mid_px (mid_px),
        .cur_px (cur_px)
    );

    sobel_window u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (s1_vld_reg),
        .in_meta  (s1_meta_reg),
        .top_px   (top_px),
        .mid_px   (mid_px),
        .cur_px   (cur_px),
        .out_vld  (grad_vld),
        .out_meta (grad_meta),
        .gx       (gx),
        .gy       (gy)
    );

    sobel_mag u_mag (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_vld     (grad_vld),
        .in_meta    (grad_meta),
        .gx         (gx),
        .gy         (gy),
        .out_vld    (out_valid),
        .edge_value (edge_value),
        .pixel_col  (pixel_col),
        .pixel_row  (pixel_row),
        .frame_end  (frame_end)
    );

    // The input side is held off only by a result waiting in the output register.
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a blocked result");

    // A frame start beat restarts the raster at the top left corner.
    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && frame_start) |=>
            ((col_reg == CW'(1)) && (row_reg == 16'd0)))
        else $error("counters did not restart on frame start");

    // Every accepted beat enters the first pipeline stage.
    a_beat_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> s1_vld_reg)
        else $error("accepted beat lost at pipeline entry");

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel edge magnitude testbench
// Streams gray frames of many sizes into the block and predicts each interior
// pixel's saturated gradient magnitude, coordinates and end-of-frame flag.
// Every output beat is checked against the oldest pending prediction, with
// random gaps on the pixel side and random stalls on the result side, except in the last test.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int LINE_DEPTH     = sobel_pkg::DEF_MAX_LINE;
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PIXELS  = 120;

    typedef struct {
        sobel_pkg::pix_t mag;
        sobel_pkg::col_t col;
        sobel_pkg::row_t row;
        logic            last;
    } edge_item_t;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 in_valid    = 1'b0;
    logic                 in_stall;
    sobel_pkg::pix_t      gray_pixel  = '0;
    logic                 frame_start = 1'b0;
    logic                 out_valid;
    logic                 out_stall   = 1'b0;
    sobel_pkg::pix_t      edge_value;
    sobel_pkg::col_t      pixel_col;
    sobel_pkg::row_t      pixel_row;
    logic                 frame_end;
    logic                 cfg_wr_en   = 1'b0;
    sobel_pkg::cfg_reg_t  cfg_index   = sobel_pkg::REG_LINE_WIDTH;
    sobel_pkg::cfg_data_t cfg_data    = '0;

    sobel_pkg::lw_t  width_reg  = sobel_pkg::lw_t'(sobel_pkg::DEF_LINE_WIDTH);
    sobel_pkg::row_t height_reg = sobel_pkg::row_t'(sobel_pkg::DEF_FRAME_HEIGHT);
    sobel_pkg::pix_t row_prev  [LINE_DEPTH] = '{default: '0};
    sobel_pkg::pix_t row_older [LINE_DEPTH] = '{default: '0};
    sobel_pkg::pix_t win [9] = '{default: '0};
    int unsigned     col_pos = 0;
    int unsigned     row_pos = 0;
    edge_item_t      edges_due [$];
    edge_item_t      due;

    int errors      = 0;
    int idle_cycles = 0;
    int stall_left  = 0;
    int pixel_style = 0;
    bit idle_on     = 1'b1;

    sobel_edge_magnitude i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .gray_pixel  (gray_pixel),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .edge_value  (edge_value),
        .pixel_col   (pixel_col),
        .pixel_row   (pixel_row),
        .frame_end   (frame_end),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic int unsigned eff_width();
        if (width_reg < 3)
            return 3;
        if (width_reg > LINE_DEPTH)
            return LINE_DEPTH;
        return 32'(width_reg);
    endfunction

    function automatic int unsigned eff_height();
        return (height_reg < 3) ? 3 : 32'(height_reg);
    endfunction

    function automatic int unsigned int_sqrt(int unsigned v);
        int unsigned root;
        int unsigned trial;
        root = 0;
        for (int b = 11; b >= 0; b--)
        begin
            trial = root | (1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    task automatic sobel_step(sobel_pkg::pix_t p, logic fs);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        int unsigned idx;
        int unsigned mag;
        int          gx;
        int          gy;
        edge_item_t  e;
        w = eff_width();
        h = eff_height();
        if (fs)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        c   = col_pos;
        r   = row_pos;
        idx = (c < LINE_DEPTH) ? c : LINE_DEPTH - 1;
        for (int k = 0; k < 3; k++)
        begin
            win[k * 3]     = win[k * 3 + 1];
            win[k * 3 + 1] = win[k * 3 + 2];
        end
        win[2] = row_older[idx];
        win[5] = row_prev[idx];
        win[8] = p;
        row_older[idx] = row_prev[idx];
        row_prev[idx]  = p;
        if (c >= 2 && r >= 2)
        begin
            gx = (int'(win[2]) + 2 * int'(win[5]) + int'(win[8]))
               - (int'(win[0]) + 2 * int'(win[3]) + int'(win[6]));
            gy = (int'(win[6]) + 2 * int'(win[7]) + int'(win[8]))
               - (int'(win[0]) + 2 * int'(win[1]) + int'(win[2]));
            mag    = int_sqrt(gx * gx + gy * gy);
            e.mag  = (mag > 255) ? 8'd255 : sobel_pkg::pix_t'(mag);
            e.col  = sobel_pkg::col_t'(c - 1);
            e.row  = sobel_pkg::row_t'(r - 1);
            e.last = (c == w - 1) && (r == h - 1);
            edges_due.push_back(e);
        end
        if (c + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end
        else
        begin
            col_pos = c + 1;
        end
    endtask

    function automatic sobel_pkg::pix_t pick_pixel();
        case (pixel_style)
            0: return sobel_pkg::pix_t'($urandom_range(0, 255));
            1: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            2: return sobel_pkg::pix_t'($urandom_range(100, 115));
            default: return ($urandom_range(0, 7) == 0) ? sobel_pkg::pix_t'($urandom) : 8'd60;
        endcase
    endfunction

    task automatic send_pixel(sobel_pkg::pix_t p, logic fs);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        gray_pixel  <= p;
        frame_start <= fs;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sobel_step(p, fs);
    endtask

    task automatic send_pixels(int n, bit start_first, int restart_odds);
        logic fs;
        for (int i = 0; i < n; i++)
        begin
            fs = (i == 0 && start_first)
              || (restart_odds != 0 && $urandom_range(1, restart_odds) == 1);
            send_pixel(pick_pixel(), fs);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (edges_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_size(int unsigned w, int unsigned h);
        cfg_wr_en <= 1'b1;
        cfg_index <= sobel_pkg::REG_LINE_WIDTH;
        cfg_data  <= sobel_pkg::cfg_data_t'(w);
        @(posedge clk);
        width_reg = sobel_pkg::lw_t'(w);
        cfg_index <= sobel_pkg::REG_FRAME_HEIGHT;
        cfg_data  <= sobel_pkg::cfg_data_t'(h);
        @(posedge clk);
        height_reg = sobel_pkg::row_t'(h);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
        if (act !== exp)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, name, exp, act);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (out_valid === 1'b1 && !out_stall)
        begin
            if (edges_due.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none actual %s %0d %0d %0d",
                         $time, "edge col row", edge_value, pixel_col, pixel_row);
                errors++;
            end
            else
            begin
                due = edges_due.pop_front();
                check_field("edge_value", 32'(due.mag), 32'(edge_value));
                check_field("pixel_col", 32'(due.col), 32'(pixel_col));
                check_field("pixel_row", 32'(due.row), 32'(pixel_row));
                check_field("frame_end", 32'(due.last), 32'(frame_end));
            end
        end
        if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left = stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 6) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left = $urandom_range(0, 2);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("%0t: watchdog expired with %0d results pending", $time, edges_due.size());
        $display("simulation failed");
        $finish;
    end

    task automatic test_reset_size();
        pixel_style = 0;
        send_pixels(2 * sobel_pkg::DEF_LINE_WIDTH + 4, 1'b1, 0);
        settle();
    endtask

    task automatic test_min_frames();
        sobel_pkg::pix_t frames [27] = '{
            8'h00, 8'h80, 8'hFF, 8'h00, 8'h80, 8'hFF, 8'h00, 8'h80, 8'hFF,
            8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
            8'd3,  8'd5,  8'd9,  8'd2,  8'd4,  8'd8,  8'd1,  8'd6,  8'd7
        };
        set_size(0, 2);
        for (int i = 0; i < 27; i++)
            send_pixel(frames[i], i == 0 || i == 18);
        settle();
    endtask

    task automatic test_mid_frame_changes();
        set_size(10, 6);
        pixel_style = 0;
        send_pixels(37, 1'b1, 0);
        settle();
        set_size(5, 3);
        send_pixels(40, 1'b0, 0);
        send_pixels(7, 1'b0, 0);
        send_pixels(20, 1'b1, 0);
        settle();
    endtask

    task automatic test_random_frames();
        int          sent;
        int unsigned w;
        int unsigned h;
        int          n;
        sent = 0;
        while (sent < RANDOM_PIXELS)
        begin
            w = $urandom_range(0, 16);
            h = $urandom_range(0, 8);
            set_size(w, h);
            pixel_style = $urandom_range(0, 3);
            n = eff_width() * eff_height() * $urandom_range(1, 2)
              + $urandom_range(0, eff_width());
            send_pixels(n, 1'b1, 200);
            settle();
            sent += n;
        end
    endtask

    task automatic test_full_rate_tail();
        idle_on = 1'b0;
        set_size(12, 5);
        pixel_style = 0;
        send_pixels(12 * 5 * 2, 1'b1, 0);
        settle();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_size();
        test_min_frames();
        test_mid_frame_changes();
        test_random_frames();
        test_full_rate_tail();
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* filelist.f */
src/sobel_pkg.sv
src/sobel_linebuf.sv
src/sobel_window.sv
src/sobel_mag.sv
src/sobel_edge_magnitude.sv
test/tb_top.sv
